// File: src/lpcre_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lpcre_pkg;

    // Field widths
    localparam int SMP_W     = 16;
    localparam int RES_W     = 17;
    localparam int COEF_W    = 16;
    localparam int ORDER_W   = 3;
    localparam int POS_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    // Predictor sizing
    localparam int MAX_ORDER_DEF = 6;
    localparam int NUM_COEF      = 6;
    localparam int FRAC_BITS     = 12;
    localparam int PROD_W        = SMP_W + COEF_W;
    // Room for up to eight taps
    localparam int ACC_W         = PROD_W + 3;

    localparam logic [POS_W-1:0]   POS_MAX       = 3'd7;
    localparam logic [ORDER_W-1:0] PRED_ORDER_RST = 3'd1;

    // Clamp bounds of the Q.12 sum and the half-up rounding offset
    localparam logic signed [ACC_W-1:0] PRED_HI    = ACC_W'(32767 * 4096);
    localparam logic signed [ACC_W-1:0] PRED_LO    = -(ACC_W'(32768 * 4096));
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(2048);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PRED_ORDER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_3     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_4     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_5     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_6     = 3'd6;

    typedef logic signed [SMP_W-1:0]  t_smp;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [RES_W-1:0]  t_res;

    // How the prediction is formed for one sample
    typedef enum logic [1:0] {
        SEL_PASS = 2'd0,
        SEL_PREV = 2'd1,
        SEL_FULL = 2'd2
    } t_pred_sel;

endpackage

`default_nettype wire

// File: src/lpcre_smp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lpcre_smp_if
    import lpcre_pkg::*;
();
    logic valid;
    logic ready;
    t_smp pcm_sample;
    logic start_of_block;

    modport source (output valid, output pcm_sample, output start_of_block, input ready);
    modport sink   (input valid, input pcm_sample, input start_of_block, output ready);
endinterface

`default_nettype wire

// File: src/lpcre_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lpcre_res_if
    import lpcre_pkg::*;
();
    logic valid;
    logic ready;
    t_res residual;

    modport source (output valid, output residual, input ready);
    modport sink   (input valid, input residual, output ready);
endinterface

`default_nettype wire

// File: src/lpc_residual_encoder_unit.sv
// Linear-prediction residual encoder, one 16-bit audio channel.
// Samples enter on i_smp (valid/ready); each accepted transaction yields
// exactly one 17-bit residual on o_res (valid/ready), in order.
// Configuration (order and six Q4.12 taps) is written through i_cfg_we,
// i_cfg_idx and i_cfg_data; the user must write it only while no
// transaction is in flight, as the block itself does not enforce this.
// Throughput: one sample per cycle while o_res is not held off. There
// are two pipeline stages: tap multiplies into a product register, then
// the adder tree, clamp, rounding and subtract into the output register.
// Stalls: when o_res is held off, the output register keeps its residual
// and the product stage can still take one more transaction; once both
// stages are full, i_smp.ready drops until the receiver takes a residual.
// Reset (synchronous, active low) empties both stages, clears the sample
// history and block position, sets the order to one and all taps to zero.
// The first sample after reset passes through unchanged.
`timescale 1ns / 1ps
`default_nettype none

module lpc_residual_encoder_unit
    import lpcre_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    lpcre_smp_if.sink                 i_smp,
    lpcre_res_if.source               o_res,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    // Configuration registers
    logic [ORDER_W-1:0] r_pred_order;
    t_coef              r_coef [NUM_COEF];

    // History and block position
    t_smp               r_past [MAX_ORDER];
    logic [POS_W-1:0]   r_position;

    // Product stage
    logic               r_s1_valid;
    t_smp               r_s1_x;
    t_smp               r_s1_prev;
    t_pred_sel          r_s1_sel;
    t_prod              r_prod [MAX_ORDER];
    t_prod              n_prod [MAX_ORDER];

    // Output stage
    logic               r_out_valid;
    t_res               r_out_res;

    logic               w_out_free;
    logic               w_in_ready;
    logic               w_in_acc;
    logic [ORDER_W-1:0] w_order;
    logic [POS_W-1:0]   w_pos;
    t_pred_sel          w_sel;
    logic signed [ACC_W-1:0] w_sum;
    logic signed [ACC_W-1:0] w_clamp;
    logic signed [ACC_W-1:0] w_biased;
    t_smp               w_pred;
    t_res               n_res;

    // Handshake
    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_in_ready  = !r_s1_valid || w_out_free;
    assign w_in_acc    = i_smp.valid && w_in_ready;
    assign i_smp.ready = w_in_ready;
    assign o_res.valid = r_out_valid;
    assign o_res.residual = r_out_res;

    // Limit the order to the tap count and pick the prediction kind
    assign w_order = (r_pred_order > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER)
                                                          : r_pred_order;
    assign w_pos   = i_smp.start_of_block ? '0 : r_position;

    always_comb begin
        if (w_pos == '0) begin
            w_sel = SEL_PASS;
        end else if (w_pos < w_order) begin
            w_sel = SEL_PREV;
        end else begin
            w_sel = SEL_FULL;
        end
    end

    // Multiply each tap in use by its past sample
    always_comb begin
        for (int j = 0; j < MAX_ORDER; j++) begin
            if (ORDER_W'(j) < w_order) begin
                n_prod[j] = PROD_W'(r_coef[j] * r_past[j]);
            end else begin
                n_prod[j] = '0;
            end
        end
    end

    // Sum the taps, clamp, round half up
    always_comb begin
        w_sum = '0;
        for (int j = 0; j < MAX_ORDER; j++) begin
            w_sum = w_sum + ACC_W'(r_prod[j]);
        end
    end

    always_comb begin
        if (w_sum > PRED_HI) begin
            w_clamp = PRED_HI;
        end else if (w_sum < PRED_LO) begin
            w_clamp = PRED_LO;
        end else begin
            w_clamp = w_sum;
        end
    end

    assign w_biased = w_clamp + ROUND_HALF;
    assign w_pred   = w_biased[FRAC_BITS +: SMP_W];

    // Form the residual
    always_comb begin
        case (r_s1_sel)
            SEL_PASS: n_res = RES_W'(r_s1_x);
            SEL_PREV: n_res = RES_W'(r_s1_x) - RES_W'(r_s1_prev);
            SEL_FULL: n_res = RES_W'(r_s1_x) - RES_W'(w_pred);
            default:  n_res = RES_W'(r_s1_x);
        endcase
    end

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pred_order <= PRED_ORDER_RST;
            for (int k = 0; k < NUM_COEF; k++) begin
                r_coef[k] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PRED_ORDER: r_pred_order <= i_cfg_data[ORDER_W-1:0];
                REG_COEF_1:     r_coef[0] <= t_coef'(i_cfg_data);
                REG_COEF_2:     r_coef[1] <= t_coef'(i_cfg_data);
                REG_COEF_3:     r_coef[2] <= t_coef'(i_cfg_data);
                REG_COEF_4:     r_coef[3] <= t_coef'(i_cfg_data);
                REG_COEF_5:     r_coef[4] <= t_coef'(i_cfg_data);
                REG_COEF_6:     r_coef[5] <= t_coef'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // Shift history and advance position on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_ORDER; k++) begin
                r_past[k] <= '0;
            end
            r_position <= '0;
        end else if (w_in_acc) begin
            r_past[0] <= i_smp.pcm_sample;
            for (int k = 1; k < MAX_ORDER; k++) begin
                r_past[k] <= r_past[k-1];
            end
            r_position <= (w_pos < POS_MAX) ? w_pos + POS_W'(1) : POS_MAX;
        end
    end

    // Advance stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_out_free) begin
                r_s1_valid <= 1'b0;
            end
            if (w_out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Load stage payloads
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_x    <= i_smp.pcm_sample;
            r_s1_prev <= r_past[0];
            r_s1_sel  <= w_sel;
            for (int k = 0; k < MAX_ORDER; k++) begin
                r_prod[k] <= n_prod[k];
            end
        end
        if (w_out_free && r_s1_valid) begin
            r_out_res <= n_res;
        end
    end

`ifndef SYNTH
    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_s1_valid && !r_out_valid))
        else $error("pipeline not empty after reset");

    // An accepted transaction occupies the product stage next cycle
    a_acc_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_s1_valid)
        else $error("accepted transaction lost");

    // A blocked product stage keeps its contents
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_out_free) |=> (r_s1_valid && $stable(r_s1_x)
                                         && $stable(r_s1_sel)))
        else $error("product stage changed while blocked");

    // A block start leaves the position at one
    a_block_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_smp.start_of_block) |=> (r_position == POS_W'(1)))
        else $error("position not restarted");
`endif

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import lpcre_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 13;
    localparam int PHASE_ITEMS = 100;

    // Index past the last register; writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam longint SUM_HI   = longint'(32767) * 4096;
    localparam longint SUM_LO   = -(longint'(32768) * 4096);
    localparam longint HALF_LSB = 2048;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    lpcre_smp_if smp_if ();
    lpcre_res_if res_if ();

    lpc_residual_encoder_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_smp      (smp_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Predictor state, mirrored from the encoder
    logic [ORDER_W-1:0] cur_order;
    t_coef              tap_coef [NUM_COEF];
    t_smp               smp_hist [MAX_ORDER_DEF];
    logic [POS_W-1:0]   blk_pos;

    t_res residual_q [$];
    t_res want_res;
    int   fail_cnt;
    int   stall_cnt;
    bit   idle_on;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic void reset_predictor();
        cur_order = PRED_ORDER_RST;
        blk_pos   = '0;
        for (int k = 0; k < NUM_COEF; k++) tap_coef[k] = '0;
        for (int k = 0; k < MAX_ORDER_DEF; k++) smp_hist[k] = '0;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            REG_PRED_ORDER: cur_order = data[ORDER_W-1:0];
            REG_COEF_1, REG_COEF_2, REG_COEF_3,
            REG_COEF_4, REG_COEF_5, REG_COEF_6: tap_coef[int'(idx) - 1] = t_coef'(data);
            default: ;
        endcase
    endfunction

    // Compute the residual of one sample and advance the history
    function automatic t_res encode_sample(t_smp x, logic sob);
        logic [POS_W-1:0] pos;
        int               taps;
        longint           acc;
        longint           pred;
        t_res             res;
        pos  = sob ? '0 : blk_pos;
        taps = (int'(cur_order) > MAX_ORDER_DEF) ? MAX_ORDER_DEF : int'(cur_order);
        if (pos == 0) begin
            res = t_res'(int'(x));
        end else if (int'(pos) < taps) begin
            res = t_res'(int'(x) - int'(smp_hist[0]));
        end else begin
            acc = 0;
            for (int j = 0; j < taps; j++)
                acc += longint'(tap_coef[j]) * longint'(smp_hist[j]);
            if (acc > SUM_HI)
                acc = SUM_HI;
            else if (acc < SUM_LO)
                acc = SUM_LO;
            // Round half up: floor of (sum + half) in Q.12
            pred = (acc + HALF_LSB) >>> FRAC_BITS;
            res  = t_res'(longint'(x) - pred);
        end
        for (int k = MAX_ORDER_DEF - 1; k > 0; k--) smp_hist[k] = smp_hist[k - 1];
        smp_hist[0] = x;
        blk_pos = (pos < POS_MAX) ? pos + 1'b1 : POS_MAX;
        return res;
    endfunction

    function automatic t_smp rand_sample();
        case ($urandom_range(9, 0))
            0:       return t_smp'(16'h7FFF);
            1:       return t_smp'(16'h8000);
            2, 3, 4: return t_smp'(int'($urandom_range(600, 0)) - 300);
            default: return t_smp'($urandom());
        endcase
    endfunction

    function automatic t_coef rand_coef(bit wild);
        if (wild) begin
            case ($urandom_range(2, 0))
                0:       return t_coef'(16'h7FFF);
                1:       return t_coef'(16'h8000);
                default: return t_coef'($urandom());
            endcase
        end
        if ($urandom_range(3, 0) == 0)
            return t_coef'($urandom());
        return t_coef'(int'($urandom_range(8192, 0)) - 4096);
    endfunction

    // Send one sample; predict its residual once the transaction completes
    task automatic send_sample(input t_smp x, input logic sob);
        @(negedge i_clk);
        while (idle_on && $urandom_range(99, 0) < 9) begin
            smp_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        smp_if.valid          <= 1'b1;
        smp_if.pcm_sample     <= x;
        smp_if.start_of_block <= sob;
        do @(posedge i_clk); while (!smp_if.ready);
        residual_q.push_back(encode_sample(x, sob));
    endtask

    // Hold off the sender until every residual has come back
    task automatic drain();
        @(negedge i_clk);
        smp_if.valid <= 1'b0;
        while (residual_q.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        apply_reg(idx, data);
    endtask

    task automatic write_taps(input logic [ORDER_W-1:0] order, input t_coef c [NUM_COEF]);
        write_reg(REG_PRED_ORDER, CFG_W'(order));
        for (int k = 0; k < NUM_COEF; k++)
            write_reg(CFG_IDX_W'(int'(REG_COEF_1) + k), c[k]);
    endtask

    // Reset defaults: first sample passes, then order one with a zero tap
    task automatic test_first_after_reset();
        send_sample(t_smp'(1234), 1'b0);
        send_sample(t_smp'(-5), 1'b0);
        send_sample(t_smp'(32767), 1'b0);
    endtask

    // Half weight on one tap exercises rounding on both signs
    task automatic test_rounding();
        drain();
        write_reg(REG_PRED_ORDER, CFG_W'(1));
        write_reg(REG_COEF_1, CFG_W'(2048));
        send_sample(t_smp'(1), 1'b1);
        send_sample(t_smp'(1), 1'b0);
        send_sample(t_smp'(-1), 1'b0);
        send_sample(t_smp'(3), 1'b0);
        send_sample(t_smp'(-3), 1'b0);
        send_sample(t_smp'(-3), 1'b0);
    endtask

    // Drive the sum past both clamp bounds and the residual to both extremes
    task automatic test_clamp();
        drain();
        write_reg(REG_PRED_ORDER, CFG_W'(2));
        write_reg(REG_COEF_1, 16'h7FFF);
        write_reg(REG_COEF_2, 16'h7FFF);
        send_sample(t_smp'(32767), 1'b1);
        send_sample(t_smp'(32767), 1'b0);
        send_sample(t_smp'(-32768), 1'b0);
        drain();
        write_reg(REG_PRED_ORDER, CFG_W'(1));
        write_reg(REG_COEF_1, 16'h8000);
        send_sample(t_smp'(32767), 1'b1);
        send_sample(t_smp'(32767), 1'b0);
    endtask

    // No taps: every later sample of the block passes unchanged
    task automatic test_order_zero();
        drain();
        write_reg(REG_PRED_ORDER, CFG_W'(0));
        send_sample(t_smp'(500), 1'b1);
        send_sample(t_smp'(600), 1'b0);
        send_sample(t_smp'(-700), 1'b0);
    endtask

    // Order seven saturates; walk through warm-up and past position saturation
    task automatic test_order_seven();
        t_coef c [NUM_COEF];
        c = '{t_coef'(4096), t_coef'(-2048), t_coef'(1024),
              t_coef'(512), t_coef'(-256), t_coef'(128)};
        drain();
        write_taps(3'd7, c);
        write_reg(REG_UNUSED, CFG_W'($urandom()));
        send_sample(t_smp'(1000), 1'b1);
        for (int k = 1; k < 9; k++)
            send_sample(t_smp'(1000 + 37 * k * k - 400 * k), 1'b0);
    endtask

    // Random phases, each with a fresh configuration
    task automatic test_random();
        t_coef            c [NUM_COEF];
        logic [ORDER_W-1:0] order;
        bit               wild;
        logic             sob;
        for (int p = 0; p < PHASES; p++) begin
            drain();
            wild = (p == 0) || (p == 7);
            case (p)
                0:       order = 3'd6;
                1:       order = 3'd1;
                default: order = ($urandom_range(4, 0) == 0) ?
                                 ORDER_W'($urandom_range(7, 0)) :
                                 ORDER_W'($urandom_range(6, 1));
            endcase
            for (int k = 0; k < NUM_COEF; k++) c[k] = rand_coef(wild);
            write_taps(order, c);
            // Run one phase with no idling on either side
            idle_on = (p != 4);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 6 && i == PHASE_ITEMS / 2)
                    drain();
                sob = (i == 0) || ($urandom_range(99, 0) < 3);
                send_sample(rand_sample(), sob);
            end
        end
        idle_on = 1'b1;
    endtask

    // Receiver: stall at random
    always @(negedge i_clk) begin
        if (!i_rst_n)
            res_if.ready <= 1'b0;
        else
            res_if.ready <= !(idle_on && $urandom_range(99, 0) < 9);
    end

    // Compare each residual with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (residual_q.size() == 0) begin
                $display("%0t: unexpected residual, expected none, actual %0d",
                         $realtime, res_if.residual);
                fail_cnt++;
            end else begin
                want_res = residual_q.pop_front();
                if (res_if.residual !== want_res) begin
                    $display("%0t: residual mismatch, expected %0d, actual %0d",
                             $realtime, want_res, res_if.residual);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = '0;
        i_cfg_data            = '0;
        smp_if.valid          = 1'b0;
        smp_if.pcm_sample     = '0;
        smp_if.start_of_block = 1'b0;
        res_if.ready          = 1'b0;
        fail_cnt              = 0;
        stall_cnt             = 0;
        idle_on               = 1'b1;
        reset_predictor();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_first_after_reset();
        test_rounding();
        test_clamp();
        test_order_zero();
        test_order_seven();
        test_random();

        drain();
        repeat (4) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
src/lpcre_pkg.sv
src/lpcre_smp_if.sv
src/lpcre_res_if.sv
src/lpc_residual_encoder_unit.sv
verif/tb.sv
